FILE: hw/rtl/seek_target_step_with_heading_macros.svh
// Assertion macros for the seek stepper.
// Used by the top level only; no other dependencies.
`ifndef SEEK_TARGET_STEP_WITH_HEADING_MACROS_SVH
`define SEEK_TARGET_STEP_WITH_HEADING_MACROS_SVH
// property that holds every clock outside reset
`define STS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// implication checked in the next cycle
`define STS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: hw/rtl/sts_pkg.sv
// Shared types, constants and angle table for the seek stepper.
// No dependencies.
package sts_pkg;
	localparam int RootIter  = 24;
	localparam int AngleIter = 16;
	localparam logic signed [33:0] Deg90 = 34'sd5898240;
	localparam logic signed [17:0] HeadMin = -18'sd17280;
	localparam logic signed [17:0] HeadMax = 18'sd5760;

	// configuration register indexes
	localparam logic CfgGain   = 1'b0;
	localparam logic CfgThresh = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIFF, ST_SQ, ST_ROOT, ST_CMP, ST_DIV, ST_STEP, ST_ROT, ST_CORD,
		ST_HEAD, ST_OUT
	} state_t;

	function automatic logic [21:0] angle_tab(input logic [4:0] i);
		logic [21:0] v;
		case (i)
			5'd0: v = 22'd2949120;  5'd1: v = 22'd1740967; 5'd2: v = 22'd919879;
			5'd3: v = 22'd466945;   5'd4: v = 22'd234379;  5'd5: v = 22'd117304;
			5'd6: v = 22'd58666;    5'd7: v = 22'd29335;   5'd8: v = 22'd14668;
			5'd9: v = 22'd7334;     5'd10: v = 22'd3667;   5'd11: v = 22'd1833;
			5'd12: v = 22'd917;     5'd13: v = 22'd458;    5'd14: v = 22'd229;
			5'd15: v = 22'd115;     5'd16: v = 22'd57;     5'd17: v = 22'd29;
			5'd18: v = 22'd14;      5'd19: v = 22'd7;      5'd20: v = 22'd4;
			5'd21: v = 22'd2;       5'd22: v = 22'd1;      default: v = 22'd0;
		endcase
		return v;
	endfunction
endpackage

FILE: hw/rtl/sts_divider.sv
// Restoring divider: (a << 30) / d, one quotient bit per cycle, 64 quotient bits.
// No dependencies.
module sts_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] num,
	input  logic [32:0] den,
	output logic        done,
	output logic [63:0] quo
);
	logic [63:0] dvd_q;
	logic [33:0] rem_q;
	logic [32:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [34:0] trial;

	assign trial = {rem_q, dvd_q[63]} - {2'b0, den_q};
	assign quo   = dvd_q;
	assign done  = busy_q && (cnt_q == 7'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'd64;
		end else if (busy_q && cnt_q != 7'd0) begin
			cnt_q <= cnt_q - 7'd1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {1'b0, num, 30'd0};
			rem_q <= 34'd0;
			den_q <= den;
		end else if (busy_q && cnt_q != 7'd0) begin
			if (!trial[34]) begin
				rem_q <= trial[33:0];
				dvd_q <= {dvd_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[32:0], dvd_q[63]};
				dvd_q <= {dvd_q[62:0], 1'b0};
			end
		end
	end
endmodule

FILE: hw/rtl/seek_target_step_with_heading.sv
// Seek stepper top level: sequencer with a shared multiplier, root, divider and CORDIC.
// Every item takes up to 24 root steps; when moving it also takes three divides and up to
// 16 CORDIC steps. One item at a time: a new target is taken only in idle, and a result
// waits in the output register.
// Asynchronous active-low reset clears position, heading, registers to defaults.
// Depends on sts_pkg, sts_divider and seek_target_step_with_heading_macros.svh.
`include "seek_target_step_with_heading_macros.svh"
module seek_target_step_with_heading (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic [15:0]        time_delta,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [15:0] heading_deg,
	output logic               moving
);
	import sts_pkg::*;

	state_t state_q, state_d;
	logic [15:0] gain_q;
	logic [30:0] thr_q;
	logic signed [31:0] cur_q [3];
	logic signed [15:0] head_q;
	logic signed [31:0] opos_q [3];
	logic signed [15:0] ohead_q;
	logic signed [31:0] tgt_q [3];
	logic [15:0] dt_q;
	logic signed [32:0] d_q [3];
	logic [32:0] a_q [3];
	logic [1:0]  k_q;
	logic        s_q;
	logic [65:0] sum_q;
	logic [65:0] sum_nx;
	logic [32:0] r_q;
	logic [5:0]  b_q;
	logic [4:0]  n_q;
	logic [32:0] len_w;
	logic        mv_w;
	logic [31:0] scale_q;
	logic [31:0] u_q [3];
	logic signed [35:0] cx_q, cy_q;
	logic signed [33:0] ang_q;
	logic [4:0]  i_q;
	logic        out_valid_q, moving_q, div_start;
	logic        div_done;
	logic [63:0] div_quo;
	logic [32:0] div_num;
	logic [32:0] mul_a, mul_b;
	logic [65:0] mul_p;
	logic [32:0] trial_r;
	logic [31:0] uk_sat;
	logic signed [33:0] newpos;
	logic [31:0] stp;
	logic signed [35:0] xs, ys;
	logic signed [33:0] h_raw;
	logic [5:0] pmsb;
	logic root_first_q;

	// shared multiplier, 33x33
	assign mul_p = mul_a * mul_b;

	assign trial_r = r_q | (33'd1 << b_q);
	assign uk_sat  = (div_quo > 64'h8000_0000) ? 32'h8000_0000 : div_quo[31:0];
	assign stp     = {4'd0, mul_p[65:38]};
	assign xs      = cx_q >>> i_q;
	assign ys      = cy_q >>> i_q;
	assign h_raw   = (ang_q - Deg90 + 34'sd512) >>> 10;
	assign sum_nx  = sum_q + mul_p;
	assign len_w   = r_q << s_q;
	assign mv_w    = {1'b0, len_w} > {3'b0, thr_q};

	always_comb begin
		mul_a = 33'd0;
		mul_b = 33'd0;
		case (state_q)
			ST_SQ:   begin mul_a = a_q[k_q] >> s_q; mul_b = a_q[k_q] >> s_q; end
			ST_ROOT: begin mul_a = trial_r; mul_b = trial_r; end
			ST_CMP:  begin mul_a = {17'd0, gain_q}; mul_b = {17'd0, dt_q}; end
			ST_STEP: begin mul_a = {1'b0, u_q[k_q]}; mul_b = {1'b0, scale_q}; end
			default: ;
		endcase
	end

	// root start bit from the completed sum of squares
	always_comb begin
		pmsb = 6'd0;
		for (int p = 0; p < 66; p++)
			if (sum_nx[p]) pmsb = 6'(p >> 1);
	end

	// next divide is launched from ST_STEP with the following component
	always_comb begin
		div_num = a_q[k_q];
		if (state_q == ST_STEP && k_q != 2'd2) div_num = a_q[k_q + 2'd1];
	end

	sts_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(len_w), .done(div_done), .quo(div_quo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid && in_ready) state_d = ST_DIFF;
			ST_DIFF: state_d = ST_SQ;
			ST_SQ:   if (k_q == 2'd2) state_d = ST_ROOT;
			ST_ROOT: if (b_q == 6'd0 || n_q == 5'(RootIter - 1)) state_d = ST_CMP;
			ST_CMP:  state_d = mv_w ? ST_DIV : ST_OUT;
			ST_DIV:  if (div_done) state_d = ST_STEP;
			ST_STEP: state_d = (k_q == 2'd2) ? ST_ROT : ST_DIV;
			ST_ROT:  state_d = (scale_q == 0 || (u_q[0] == 0 && u_q[2] == 0)) ? ST_HEAD
				: ST_CORD;
			ST_CORD: if (i_q == 5'(AngleIter - 1)) state_d = ST_HEAD;
			ST_HEAD: state_d = ST_OUT;
			ST_OUT:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		div_start = (state_q == ST_CMP && state_d == ST_DIV) ||
			(state_q == ST_STEP && k_q != 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gain_q <= 16'd2560;
			thr_q <= 31'd6554;
			for (int k = 0; k < 3; k++) cur_q[k] <= '0;
			head_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == CfgGain) gain_q <= cfg_data[15:0];
			if (cfg_we && cfg_index == CfgThresh) thr_q <= cfg_data;
			if (state_q == ST_OUT && state_d == ST_IDLE) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (state_q == ST_STEP)
				cur_q[k_q] <= newpos > 34'sh7FFFFFFF ? 32'sh7FFFFFFF :
					newpos < -34'sh80000000 ? 32'sh80000000 : newpos[31:0];
			if (state_q == ST_HEAD)
				head_q <= h_raw < 34'(HeadMin) ? 16'(HeadMin) :
					h_raw > 34'(HeadMax) ? 16'(HeadMax) : h_raw[15:0];
		end
	end

	always_comb begin
		if (d_q[k_q][32])
			newpos = 34'(cur_q[k_q]) - 34'(stp);
		else
			newpos = 34'(cur_q[k_q]) + 34'(stp);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				tgt_q[0] <= target_x; tgt_q[1] <= target_y; tgt_q[2] <= target_z;
				dt_q <= time_delta; k_q <= 2'd0; sum_q <= '0;
			end
			ST_DIFF: begin
				for (int k = 0; k < 3; k++) begin
					d_q[k] <= 33'(tgt_q[k]) - 33'(cur_q[k]);
					a_q[k] <= (33'(tgt_q[k]) - 33'(cur_q[k])) < 0 ?
						-(33'(tgt_q[k]) - 33'(cur_q[k])) : 33'(tgt_q[k]) - 33'(cur_q[k]);
				end
				s_q <= 1'b0;
			end
			ST_SQ: begin
				if (k_q == 2'd0)
					s_q <= a_q[0][31] | a_q[0][32] | a_q[1][31] | a_q[1][32] |
						a_q[2][31] | a_q[2][32];
				// s resolved above on first pass; first product uses old s so redo
				if (k_q == 2'd0 && (a_q[0][32:31] != 0 || a_q[1][32:31] != 0 ||
					a_q[2][32:31] != 0) && !s_q) begin
					k_q <= 2'd0;
				end else begin
					sum_q <= sum_nx;
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				end
				if (k_q == 2'd2) b_q <= pmsb;
				r_q <= '0; n_q <= '0;
			end
			ST_ROOT: begin
				if (mul_p <= sum_q && sum_q != 0) r_q <= trial_r;
				b_q <= b_q - 6'd1; n_q <= n_q + 5'd1;
			end
			ST_CMP: begin
				scale_q <= mul_p[31:0]; k_q <= 2'd0;
			end
			ST_DIV: if (div_done) u_q[k_q] <= uk_sat;
			ST_STEP: k_q <= k_q + 2'd1;
			ST_ROT: begin
				i_q <= '0;
				if (d_q[2][32] && u_q[2] != 0) begin
					cx_q <= 36'(u_q[0]);
					if (!(d_q[0][32] && u_q[0] != 0)) begin
						cy_q <= 36'(u_q[2]);
						ang_q <= (scale_q == 0) ? 34'sd0 : Deg90;
					end else begin
						cy_q <= -36'(u_q[2]);
						ang_q <= (scale_q == 0) ? 34'sd0 : -Deg90;
					end
				end else begin
					cx_q <= d_q[2][32] ? -36'(u_q[2]) : 36'(u_q[2]);
					cy_q <= d_q[0][32] ? -36'(u_q[0]) : 36'(u_q[0]);
					ang_q <= '0;
				end
			end
			ST_CORD: begin
				if (!cy_q[35]) begin
					cx_q <= cx_q + ys; cy_q <= cy_q - xs;
					ang_q <= ang_q + 34'(angle_tab(i_q));
				end else begin
					cx_q <= cx_q - ys; cy_q <= cy_q + xs;
					ang_q <= ang_q - 34'(angle_tab(i_q));
				end
				i_q <= i_q + 5'd1;
			end
			ST_OUT: begin
				if (state_d == ST_IDLE) begin
					for (int k = 0; k < 3; k++) opos_q[k] <= cur_q[k];
					ohead_q <= head_q;
					moving_q <= mv_w;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) root_first_q <= 1'b0;
		else root_first_q <= (state_q == ST_SQ && state_d == ST_ROOT);
	end

	assign out_valid   = out_valid_q;
	assign pos_x       = opos_q[0];
	assign pos_y       = opos_q[1];
	assign pos_z       = opos_q[2];
	assign heading_deg = ohead_q;
	assign moving      = moving_q;

	`STS_ASSERT(a_ready_idle, in_ready == (state_q == ST_IDLE), "ready outside idle")
	`STS_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "accepted while busy")
	`STS_ASSERT(a_head_range, !out_valid || (heading_deg >= -16'sd17280 &&
		heading_deg <= 16'sd5760), "heading out of range")
	`STS_ASSERT(a_root_entry, !root_first_q || state_q == ST_ROOT || state_q == ST_CMP,
		"root sequence skipped")
endmodule
